[design/slvt_pkg.sv]
// Shared constants, types and helpers of the slew-limited vehicle tracker.
package slvt_pkg;

  localparam int unsigned OSC_PERIOD_MS = 1200;
  localparam int unsigned OSC_AMPLITUDE = 1047;
  localparam int unsigned MS_PER_S      = 1000;
  localparam int unsigned PHASE_W       = 11;

  // sine polynomial, Q14 in, Q16 out
  localparam int unsigned Q14_ONE = 16384;
  localparam int unsigned Q16_ONE = 65536;
  localparam int unsigned SIN_C1  = 4640;
  localparam int unsigned SIN_C2  = 42047;
  localparam int unsigned SIN_C3  = 102944;

  // serial divider: 32-bit dividend, 16-bit divisor, two quotient bits a cycle
  localparam int unsigned DIVIDEND_W = 32;
  localparam int unsigned DIVISOR_W  = 16;
  localparam int unsigned DIV_STEPS  = DIVIDEND_W / 2;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [14:0] TARGET_SPEED_RST = 15'd0;
  localparam logic [13:0] ACCEL_RATE_RST   = 14'd100;
  localparam logic [15:0] STEER_RATE_RST   = 16'd698;
  localparam logic [15:0] REF_TIMEOUT_RST  = 16'd2000;

  typedef enum logic [1:0] {
    CFG_TARGET_SPEED,
    CFG_ACCEL_RATE,
    CFG_STEER_RATE,
    CFG_REF_TIMEOUT
  } cfg_idx_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_SPD,
    OP_DIV_K,
    OP_SPD_UPD,
    OP_DIV_ACC,
    OP_SPD_EL,
    OP_MUL_STR,
    OP_DIV_OSC,
    OP_STEER,
    OP_Z,
    OP_Z2,
    OP_T1,
    OP_T2,
    OP_SCALE,
    OP_OSC_OUT,
    OP_EMIT
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_SPD,
    ST_DIV_SPD,
    ST_WAIT_SPD,
    ST_DIV_ACC,
    ST_WAIT_ACC,
    ST_STEER_GO,
    ST_DIV_STR,
    ST_WAIT_STR,
    ST_WAIT_OSC,
    ST_Z2,
    ST_T1,
    ST_T2,
    ST_SCALE,
    ST_OSC_OUT,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic quo_nz;
    logic eng_tick;
    logic out_free;
  } dp_sts_t;

  function automatic logic signed [15:0] sat16(input logic signed [24:0] v);
    logic signed [15:0] r;
    if (v > 25'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -25'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

[design/slvt_if.sv]
// Valid/ready channel interfaces for tick items and tracker results.
interface slvt_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] ref_angle;
  logic               ref_fresh;
  logic               engage_write;
  logic               engage_value;

  modport source (output valid, ref_angle, ref_fresh, engage_write, engage_value,
                  input ready);
  modport sink (input valid, ref_angle, ref_fresh, engage_write, engage_value,
                output ready);
endinterface

interface slvt_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] speed_now;
  logic signed [15:0] angle_now;
  logic               ref_late;
  logic               engaged_now;

  modport source (output valid, speed_now, angle_now, ref_late, engaged_now,
                  input ready);
  modport sink (input valid, speed_now, angle_now, ref_late, engaged_now,
                output ready);
endinterface

[design/slew_limited_vehicle_tracker_unit.sv]
// Slew-limited vehicle tracker top level: sequencer plus datapath.
// One tick at a time; the time from accepted tick to result valid is set by up to three
// passes of the shared radix-4 divider (/1000, /accel, then /1000 when engaged or /period)
// plus a five-step multiply chain for the sine when disengaged.
// Next tick is taken as soon as the previous result sits in the output register.
// Asynchronous active-low reset: state cleared, configuration registers to their defaults.
module slew_limited_vehicle_tracker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  slvt_in_if.sink     in_ch_i,
  slvt_out_if.source  out_ch_o
);

  slvt_pkg::dp_cmd_t cmd;
  slvt_pkg::dp_sts_t sts;

  slvt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch_i.valid),
    .in_ready_o (in_ch_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  slvt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .ref_angle_i    (in_ch_i.ref_angle),
    .ref_fresh_i    (in_ch_i.ref_fresh),
    .engage_write_i (in_ch_i.engage_write),
    .engage_value_i (in_ch_i.engage_value),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (out_ch_o.ready),
    .out_valid_o    (out_ch_o.valid),
    .speed_now_o    (out_ch_o.speed_now),
    .angle_now_o    (out_ch_o.angle_now),
    .ref_late_o     (out_ch_o.ref_late),
    .engaged_now_o  (out_ch_o.engaged_now)
  );

  // one tick in flight: the sequencer leaves idle straight after a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch_i.valid && in_ch_i.ready) |=> !in_ch_i.ready)
    else $error("tick accepted while another is in flight");

  // a finished result never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == slvt_pkg::OP_EMIT) |-> sts.out_free)
    else $error("result register overwritten");

  // a timeout always leaves the tracker disengaged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch_o.valid && out_ch_o.ref_late) |-> !out_ch_o.engaged_now)
    else $error("late reference but still engaged");

  // divider completion is a single-cycle pulse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.div_done |=> !sts.div_done)
    else $error("divider done held");

endmodule

[design/slvt_div.sv]
// Restoring unsigned divider, two quotient bits per cycle.
module slvt_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [slvt_pkg::DIVIDEND_W-1:0]     dividend_i,
  input  logic [slvt_pkg::DIVISOR_W-1:0]      divisor_i,
  output logic [slvt_pkg::DIVIDEND_W-1:0]     quotient_o,
  output logic                                done_o
);

  localparam int unsigned DW = slvt_pkg::DIVISOR_W;
  localparam int unsigned NW = slvt_pkg::DIVIDEND_W;

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [slvt_pkg::DIV_CNT_W-1:0]      cnt_q, cnt_d;
  logic [NW-1:0]                       quo_q, quo_d;
  logic [DW-1:0]                       rem_q, rem_d;
  logic [DW-1:0]                       dvs_q, dvs_d;

  logic [DW:0] r1, r1s, r2, r2s;
  logic        ge1, ge2;

  assign r1  = {rem_q, quo_q[NW-1]};
  assign ge1 = r1 >= {1'b0, dvs_q};
  assign r1s = ge1 ? r1 - {1'b0, dvs_q} : r1;
  assign r2  = {r1s[DW-1:0], quo_q[NW-2]};
  assign ge2 = r2 >= {1'b0, dvs_q};
  assign r2s = ge2 ? r2 - {1'b0, dvs_q} : r2;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[NW-3:0], ge1, ge2};
      rem_d = r2s[DW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == slvt_pkg::DIV_CNT_W'(slvt_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

[design/slvt_dp.sv]
// Tracker datapath: state, configuration, shared multiplier, divider, result register.
module slvt_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic signed [15:0]  ref_angle_i,
  input  logic                ref_fresh_i,
  input  logic                engage_write_i,
  input  logic                engage_value_i,
  input  slvt_pkg::dp_cmd_t   cmd_i,
  output slvt_pkg::dp_sts_t   sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic signed [15:0]  speed_now_o,
  output logic signed [15:0]  angle_now_o,
  output logic                ref_late_o,
  output logic                engaged_now_o
);

  localparam int unsigned PW = slvt_pkg::PHASE_W;

  // configuration
  logic [14:0] target_q, target_d;
  logic [13:0] accel_q, accel_d;
  logic [15:0] steer_q, steer_d;
  logic [15:0] timeout_q, timeout_d;

  // architectural state
  logic signed [15:0] speed_q, speed_d;
  logic signed [15:0] angle_q, angle_d;
  logic [15:0]        spd_el_q, spd_el_d;
  logic [15:0]        str_el_q, str_el_d;
  logic [15:0]        age_q, age_d;
  logic [PW-1:0]      phase_q, phase_d;
  logic               engaged_q, engaged_d;

  // per-tick working registers
  logic               eng_tick_q, eng_tick_d;
  logic               late_q, late_d;
  logic signed [15:0] ref_q, ref_d;
  logic [31:0]        prod_q, prod_d;
  logic [14:0]        z_q, z_d;
  logic [14:0]        z2_q, z2_d;
  logic [1:0]         quad_q, quad_d;

  // result register
  logic               out_valid_q, out_valid_d;
  logic signed [15:0] out_speed_q, out_speed_d;
  logic signed [15:0] out_angle_q, out_angle_d;
  logic               out_late_q, out_late_d;
  logic               out_eng_q, out_eng_d;

  // divider hookup
  logic                                div_start;
  logic [slvt_pkg::DIVIDEND_W-1:0]     div_dividend;
  logic [slvt_pkg::DIVISOR_W-1:0]      div_divisor;
  logic [slvt_pkg::DIVIDEND_W-1:0]     quo;
  logic                                div_done;

  // shared multiplier
  logic [20:0] mul_a;
  logic [16:0] mul_b;
  logic [37:0] mul_p;

  // helpers
  logic               eng_w;
  logic [15:0]        spd_el_inc, str_el_inc;
  logic               speed_gt, angle_gt;
  logic signed [24:0] speed_ext, angle_ext, speed_sum, angle_sum;
  logic [24:0]        sstep_ext, astep_ext;
  logic signed [15:0] steer_cand, osc_cand;
  logic [15:0]        f16;
  logic [14:0]        z_new;
  logic [15:0]        t1;
  logic [16:0]        t2;
  logic [17:0]        s_raw;
  logic [16:0]        s_cap;
  logic [15:0]        mag;

  slvt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  assign eng_w      = engage_write_i ? engage_value_i : engaged_q;
  assign spd_el_inc = (spd_el_q == 16'hffff) ? spd_el_q : spd_el_q + 16'd1;
  assign str_el_inc = (str_el_q == 16'hffff) ? str_el_q : str_el_q + 16'd1;

  assign speed_gt  = $signed({speed_q[15], speed_q}) > $signed({2'b00, target_q});
  assign speed_ext = {{9{speed_q[15]}}, speed_q};
  assign sstep_ext = {4'b0, quo[20:0]};
  assign speed_sum = speed_gt ? speed_ext - $signed(sstep_ext)
                              : speed_ext + $signed(sstep_ext);

  assign angle_gt   = angle_q > ref_q;
  assign angle_ext  = {{9{angle_q[15]}}, angle_q};
  assign astep_ext  = {2'b0, quo[22:0]};
  assign angle_sum  = angle_gt ? angle_ext - $signed(astep_ext)
                               : angle_ext + $signed(astep_ext);
  assign steer_cand = (quo == '0) ? angle_q : slvt_pkg::sat16(angle_sum);

  // sine: quadrant fold of the Q16 phase, then the Q14 polynomial steps
  assign f16   = quo[15:0];
  assign z_new = f16[14] ? 15'(slvt_pkg::Q14_ONE) - {1'b0, f16[13:0]} : {1'b0, f16[13:0]};
  assign t1    = 16'(slvt_pkg::SIN_C2) - prod_q[29:14];
  assign t2    = 17'(slvt_pkg::SIN_C3) - {1'b0, prod_q[29:14]};
  assign s_raw = prod_q[31:14];
  assign s_cap = (s_raw > 18'(slvt_pkg::Q16_ONE)) ? 17'(slvt_pkg::Q16_ONE) : s_raw[16:0];
  assign mag   = prod_q[31:16];
  assign osc_cand = quad_q[1] ? -$signed(mag) : $signed(mag);

  assign mul_p = mul_a * mul_b;

  always_comb begin
    target_d    = target_q;
    accel_d     = accel_q;
    steer_d     = steer_q;
    timeout_d   = timeout_q;
    speed_d     = speed_q;
    angle_d     = angle_q;
    spd_el_d    = spd_el_q;
    str_el_d    = str_el_q;
    age_d       = age_q;
    phase_d     = phase_q;
    engaged_d   = engaged_q;
    eng_tick_d  = eng_tick_q;
    late_d      = late_q;
    ref_d       = ref_q;
    prod_d      = prod_q;
    z_d         = z_q;
    z2_d        = z2_q;
    quad_d      = quad_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_speed_d = out_speed_q;
    out_angle_d = out_angle_q;
    out_late_d  = out_late_q;
    out_eng_d   = out_eng_q;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_dividend = prod_q;
    div_divisor  = slvt_pkg::DIVISOR_W'(slvt_pkg::MS_PER_S);

    if (cfg_we_i) begin
      unique case (slvt_pkg::cfg_idx_e'(cfg_idx_i))
        slvt_pkg::CFG_TARGET_SPEED: target_d  = cfg_wdata_i[14:0];
        slvt_pkg::CFG_ACCEL_RATE:   accel_d   = cfg_wdata_i[13:0];
        slvt_pkg::CFG_STEER_RATE:   steer_d   = cfg_wdata_i;
        slvt_pkg::CFG_REF_TIMEOUT:  timeout_d = cfg_wdata_i;
      endcase
    end

    unique case (cmd_i.op)
      slvt_pkg::OP_NONE: ;
      slvt_pkg::OP_LOAD: begin
        eng_tick_d = eng_w;
        ref_d      = ref_angle_i;
        phase_d    = (phase_q == PW'(slvt_pkg::OSC_PERIOD_MS - 1)) ? '0 : phase_q + 1'b1;
        spd_el_d   = spd_el_inc;
        str_el_d   = str_el_inc;
        late_d     = 1'b0;
        engaged_d  = eng_w;
        if (ref_fresh_i || !eng_w) begin
          age_d = '0;
        end else if (age_q >= timeout_q) begin
          late_d    = 1'b1;
          engaged_d = 1'b0;
          age_d     = '0;
        end else begin
          age_d = age_q + 16'd1;
        end
      end
      slvt_pkg::OP_MUL_SPD: begin
        mul_a  = {7'b0, accel_q};
        mul_b  = {1'b0, spd_el_q};
        prod_d = mul_p[31:0];
      end
      slvt_pkg::OP_DIV_K: begin
        div_start = 1'b1;
      end
      slvt_pkg::OP_SPD_UPD: begin
        // a zero step leaves the speed as it is
        speed_d = slvt_pkg::sat16(speed_sum);
        mul_a   = quo[20:0];
        mul_b   = 17'(slvt_pkg::MS_PER_S);
        prod_d  = mul_p[31:0];
      end
      slvt_pkg::OP_DIV_ACC: begin
        div_start   = 1'b1;
        div_divisor = {2'b0, accel_q};
      end
      slvt_pkg::OP_SPD_EL: begin
        spd_el_d = spd_el_q - quo[15:0];
      end
      slvt_pkg::OP_MUL_STR: begin
        mul_a  = {5'b0, steer_q};
        mul_b  = {1'b0, str_el_q};
        prod_d = mul_p[31:0];
      end
      slvt_pkg::OP_DIV_OSC: begin
        div_start    = 1'b1;
        div_dividend = {5'b0, phase_q, 16'b0};
        div_divisor  = slvt_pkg::DIVISOR_W'(slvt_pkg::OSC_PERIOD_MS);
      end
      slvt_pkg::OP_STEER: begin
        if (steer_cand != angle_q) begin
          angle_d  = steer_cand;
          str_el_d = '0;
        end
      end
      slvt_pkg::OP_Z: begin
        z_d    = z_new;
        quad_d = f16[15:14];
        mul_a  = {6'b0, z_new};
        mul_b  = {2'b0, z_new};
        prod_d = mul_p[31:0];
      end
      slvt_pkg::OP_Z2: begin
        z2_d   = prod_q[28:14];
        mul_a  = 21'(slvt_pkg::SIN_C1);
        mul_b  = {2'b0, prod_q[28:14]};
        prod_d = mul_p[31:0];
      end
      slvt_pkg::OP_T1: begin
        mul_a  = {5'b0, t1};
        mul_b  = {2'b0, z2_q};
        prod_d = mul_p[31:0];
      end
      slvt_pkg::OP_T2: begin
        mul_a  = {4'b0, t2};
        mul_b  = {2'b0, z_q};
        prod_d = mul_p[31:0];
      end
      slvt_pkg::OP_SCALE: begin
        mul_a  = 21'(slvt_pkg::OSC_AMPLITUDE);
        mul_b  = s_cap;
        prod_d = mul_p[31:0];
      end
      slvt_pkg::OP_OSC_OUT: begin
        if (osc_cand != angle_q) begin
          angle_d  = osc_cand;
          str_el_d = '0;
        end
      end
      slvt_pkg::OP_EMIT: begin
        out_valid_d = 1'b1;
        out_speed_d = speed_q;
        out_angle_d = angle_q;
        out_late_d  = late_q;
        out_eng_d   = engaged_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= slvt_pkg::TARGET_SPEED_RST;
      accel_q     <= slvt_pkg::ACCEL_RATE_RST;
      steer_q     <= slvt_pkg::STEER_RATE_RST;
      timeout_q   <= slvt_pkg::REF_TIMEOUT_RST;
      speed_q     <= '0;
      angle_q     <= '0;
      spd_el_q    <= '0;
      str_el_q    <= '0;
      age_q       <= '0;
      phase_q     <= '0;
      engaged_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      target_q    <= target_d;
      accel_q     <= accel_d;
      steer_q     <= steer_d;
      timeout_q   <= timeout_d;
      speed_q     <= speed_d;
      angle_q     <= angle_d;
      spd_el_q    <= spd_el_d;
      str_el_q    <= str_el_d;
      age_q       <= age_d;
      phase_q     <= phase_d;
      engaged_q   <= engaged_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    eng_tick_q  <= eng_tick_d;
    late_q      <= late_d;
    ref_q       <= ref_d;
    prod_q      <= prod_d;
    z_q         <= z_d;
    z2_q        <= z2_d;
    quad_q      <= quad_d;
    out_speed_q <= out_speed_d;
    out_angle_q <= out_angle_d;
    out_late_q  <= out_late_d;
    out_eng_q   <= out_eng_d;
  end

  assign sts_o.div_done = div_done;
  assign sts_o.quo_nz   = |quo;
  assign sts_o.eng_tick = eng_tick_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign speed_now_o   = out_speed_q;
  assign angle_now_o   = out_angle_q;
  assign ref_late_o    = out_late_q;
  assign engaged_now_o = out_eng_q;

endmodule

[design/slvt_ctrl.sv]
// Tracker sequencer: steps the datapath through one tick transaction.
module slvt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  slvt_pkg::dp_sts_t sts_i,
  output slvt_pkg::dp_cmd_t cmd_o
);

  slvt_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slvt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = slvt_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      slvt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = slvt_pkg::OP_LOAD;
          state_d  = slvt_pkg::ST_MUL_SPD;
        end
      end
      slvt_pkg::ST_MUL_SPD: begin
        cmd_o.op = slvt_pkg::OP_MUL_SPD;
        state_d  = slvt_pkg::ST_DIV_SPD;
      end
      slvt_pkg::ST_DIV_SPD: begin
        cmd_o.op = slvt_pkg::OP_DIV_K;
        state_d  = slvt_pkg::ST_WAIT_SPD;
      end
      slvt_pkg::ST_WAIT_SPD: begin
        if (sts_i.div_done) begin
          cmd_o.op = slvt_pkg::OP_SPD_UPD;
          // elapsed only gives back time when the step was nonzero
          state_d  = sts_i.quo_nz ? slvt_pkg::ST_DIV_ACC : slvt_pkg::ST_STEER_GO;
        end
      end
      slvt_pkg::ST_DIV_ACC: begin
        cmd_o.op = slvt_pkg::OP_DIV_ACC;
        state_d  = slvt_pkg::ST_WAIT_ACC;
      end
      slvt_pkg::ST_WAIT_ACC: begin
        if (sts_i.div_done) begin
          cmd_o.op = slvt_pkg::OP_SPD_EL;
          state_d  = slvt_pkg::ST_STEER_GO;
        end
      end
      slvt_pkg::ST_STEER_GO: begin
        if (sts_i.eng_tick) begin
          cmd_o.op = slvt_pkg::OP_MUL_STR;
          state_d  = slvt_pkg::ST_DIV_STR;
        end else begin
          cmd_o.op = slvt_pkg::OP_DIV_OSC;
          state_d  = slvt_pkg::ST_WAIT_OSC;
        end
      end
      slvt_pkg::ST_DIV_STR: begin
        cmd_o.op = slvt_pkg::OP_DIV_K;
        state_d  = slvt_pkg::ST_WAIT_STR;
      end
      slvt_pkg::ST_WAIT_STR: begin
        if (sts_i.div_done) begin
          cmd_o.op = slvt_pkg::OP_STEER;
          state_d  = slvt_pkg::ST_FINISH;
        end
      end
      slvt_pkg::ST_WAIT_OSC: begin
        if (sts_i.div_done) begin
          cmd_o.op = slvt_pkg::OP_Z;
          state_d  = slvt_pkg::ST_Z2;
        end
      end
      slvt_pkg::ST_Z2: begin
        cmd_o.op = slvt_pkg::OP_Z2;
        state_d  = slvt_pkg::ST_T1;
      end
      slvt_pkg::ST_T1: begin
        cmd_o.op = slvt_pkg::OP_T1;
        state_d  = slvt_pkg::ST_T2;
      end
      slvt_pkg::ST_T2: begin
        cmd_o.op = slvt_pkg::OP_T2;
        state_d  = slvt_pkg::ST_SCALE;
      end
      slvt_pkg::ST_SCALE: begin
        cmd_o.op = slvt_pkg::OP_SCALE;
        state_d  = slvt_pkg::ST_OSC_OUT;
      end
      slvt_pkg::ST_OSC_OUT: begin
        cmd_o.op = slvt_pkg::OP_OSC_OUT;
        state_d  = slvt_pkg::ST_FINISH;
      end
      slvt_pkg::ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.op = slvt_pkg::OP_EMIT;
          state_d  = slvt_pkg::ST_IDLE;
        end
      end
      default: state_d = slvt_pkg::ST_IDLE;
    endcase
  end

endmodule
